/* src/triangle_barycentric_gradients_macros.svh */
// Assertion macros shared by the triangle barycentric gradient block.
`ifndef TRIANGLE_BARYCENTRIC_GRADIENTS_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_GRADIENTS_MACROS_SVH
`ifndef SYNTHESIS
`define TBG_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TBG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TBG_ASSERT(label, ante, cons)
`define TBG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/tbg_pkg.sv */
// Widths, latencies and types for the triangle barycentric gradient block.
package tbg_pkg;
   localparam int COORD_W   = 16;                 // Q12.4 coordinate
   localparam int DIFF_W    = COORD_W + 1;        // coordinate difference
   localparam int PROD_W    = 2 * DIFF_W;         // product of two differences
   localparam int NUM_W     = PROD_W + 1;         // cross product / numerator
   localparam int MAG_W     = NUM_W;              // divider operand magnitude
   localparam int MIN_W     = 34;                 // degenerate threshold register
   localparam int AREA_W    = 35;                 // doubled area output
   localparam int OUT_W     = 32;
   localparam int FRAC_W    = 24;
   localparam int INT_BITS  = OUT_W - FRAC_W;     // integer quotient bits
   localparam int FRAC_STEPS = FRAC_W + 1;        // fraction bits plus round bit
   localparam int QUOT_W    = INT_BITS + FRAC_STEPS;
   localparam int CMP_W     = MAG_W + INT_BITS + 1;
   localparam int DIV_LAST  = INT_BITS + FRAC_STEPS;  // last quotient stage
   localparam int DIV_LAT   = DIV_LAST + 2;       // entry + bit stages + output
   localparam int NUM_DIV   = 8;
   localparam int NUM_GRAD  = 6;

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [NUM_W-1:0]  num_type;
   typedef logic signed [OUT_W-1:0]  fx_type;
endpackage

/* src/tbg_div.sv */
// Pipelined restoring divider: num * 2^FRAC_W / den, rounded, saturated to 32 bits.
module tbg_div import tbg_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  num_type num,
   input  num_type den,
   output fx_type  quot
);
   logic [MAG_W-1:0]  r_ff   [0:DIV_LAST];
   logic [MAG_W-1:0]  d_ff   [0:DIV_LAST];
   logic [QUOT_W-1:0] q_ff   [0:DIV_LAST];
   logic              sat_ff [0:DIV_LAST];
   logic              neg_ff [0:DIV_LAST];
   fx_type            quot_ff;
   fx_type            quot_in;

   logic [MAG_W-1:0]  n_mag;
   logic [MAG_W-1:0]  d_mag;
   logic              sat_in;
   logic [QUOT_W:0]   q_inc;
   logic [QUOT_W-1:0] m;

   always_comb begin
      n_mag  = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
      d_mag  = den[NUM_W-1] ? MAG_W'(-den) : MAG_W'(den);
      // integer part of 2^INT_BITS or more saturates
      sat_in = CMP_W'(n_mag) >= (CMP_W'(d_mag) << INT_BITS);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= n_mag;
         d_ff[0]   <= d_mag;
         q_ff[0]   <= '0;
         sat_ff[0] <= sat_in;
         neg_ff[0] <= num[NUM_W-1] ^ den[NUM_W-1];
      end
   end

   for (genvar s = 1; s <= DIV_LAST; s++) begin : g_stage
      logic [MAG_W-1:0] r_in;
      logic             bit_in;
      if (s <= INT_BITS) begin : g_int
         localparam int K = INT_BITS - s;
         logic [CMP_W-1:0] shifted;
         always_comb begin
            shifted = CMP_W'(d_ff[s-1]) << K;
            bit_in  = CMP_W'(r_ff[s-1]) >= shifted;
            r_in    = bit_in ? MAG_W'(CMP_W'(r_ff[s-1]) - shifted) : r_ff[s-1];
         end
      end else begin : g_frac
         logic [MAG_W:0] twice;
         always_comb begin
            twice  = {r_ff[s-1], 1'b0};
            bit_in = twice >= {1'b0, d_ff[s-1]};
            r_in   = bit_in ? MAG_W'(twice - {1'b0, d_ff[s-1]}) : MAG_W'(twice);
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]   <= r_in;
            d_ff[s]   <= d_ff[s-1];
            q_ff[s]   <= {q_ff[s-1][QUOT_W-2:0], bit_in};
            sat_ff[s] <= sat_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
      end
   end

   // last quotient bit is the round bit: ties go away from zero
   always_comb begin
      q_inc = {1'b0, q_ff[DIV_LAST]} + (QUOT_W+1)'(1);
      m     = sat_ff[DIV_LAST] ? (QUOT_W'(1) << OUT_W) : q_inc[QUOT_W:1];
      if (neg_ff[DIV_LAST]) begin
         quot_in = (m > (QUOT_W'(1) << (OUT_W-1))) ? {1'b1, {(OUT_W-1){1'b0}}}
                                                   : OUT_W'(-m);
      end else begin
         quot_in = (m > {2'b00, {(OUT_W-1){1'b1}}}) ? {1'b0, {(OUT_W-1){1'b1}}}
                                                   : OUT_W'(m);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;
endmodule

/* src/triangle_barycentric_gradients.sv */
// Triangle barycentric weights and gradients, top level.
// Takes one transaction per clock while the output is not stalled: three
// stages form the edge vectors, products and cross products, then eight pipelined
// restoring dividers (33 quotient bits, one per stage, 35 stages with entry and output)
// run side by side and a final stage forms weight 0 and zeroes degenerate triangles.
// When a result waits on rsp_ready the whole pipeline holds, so req_ready follows the
// output stage. The threshold register is written through the csr_ port, which is
// always ready.
module triangle_barycentric_gradients import tbg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [MIN_W-1:0]         csr_min_twice_area,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_corner0_x,
   input  logic signed [COORD_W-1:0] req_corner0_y,
   input  logic signed [COORD_W-1:0] req_corner1_x,
   input  logic signed [COORD_W-1:0] req_corner1_y,
   input  logic signed [COORD_W-1:0] req_corner2_x,
   input  logic signed [COORD_W-1:0] req_corner2_y,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [OUT_W-1:0]  rsp_weight0,
   output logic signed [OUT_W-1:0]  rsp_weight1,
   output logic signed [OUT_W-1:0]  rsp_weight2,
   output logic signed [OUT_W-1:0]  rsp_grad0_dx,
   output logic signed [OUT_W-1:0]  rsp_grad1_dx,
   output logic signed [OUT_W-1:0]  rsp_grad2_dx,
   output logic signed [OUT_W-1:0]  rsp_grad0_dy,
   output logic signed [OUT_W-1:0]  rsp_grad1_dy,
   output logic signed [OUT_W-1:0]  rsp_grad2_dy,
   output logic signed [AREA_W-1:0] rsp_doubled_area,
   output logic                     rsp_valid_res
);
`include "triangle_barycentric_gradients_macros.svh"

   logic              en;
   logic [MIN_W-1:0]  min_ff;

   // stage A: differences
   logic     a_valid_ff;
   diff_type qx_ff, qy_ff, ux_ff, uy_ff, vx_ff, vy_ff;
   diff_type a_grad_ff [0:NUM_GRAD-1];
   diff_type grad_in   [0:NUM_GRAD-1];
   // stage B: products
   logic     b_valid_ff;
   prod_type p_qxvy_ff, p_qyvx_ff, p_qyux_ff, p_qxuy_ff, p_uxvy_ff, p_vxuy_ff;
   diff_type b_grad_ff [0:NUM_GRAD-1];
   // stage C: cross products
   logic     c_valid_ff;
   num_type  n1_ff, n2_ff, den_ff;
   diff_type c_grad_ff [0:NUM_GRAD-1];
   // side band next to the dividers
   logic              aux_valid_ff [0:DIV_LAT-1];
   logic              aux_nd_ff    [0:DIV_LAT-1];
   num_type           aux_den_ff   [0:DIV_LAT-1];
   num_type           den_mag;
   logic              nd_in;
   num_type           div_num [0:NUM_DIV-1];
   fx_type            div_q   [0:NUM_DIV-1];
   // output stage
   logic              out_valid_ff;
   fx_type            out_ff [0:NUM_DIV];
   fx_type            out_in [0:NUM_DIV];
   logic [AREA_W-1:0] area_ff, area_in;
   logic              res_ff, res_in;
   logic signed [OUT_W+1:0] w0_sum;

   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
      end else if (csr_valid) begin
         min_ff <= csr_min_twice_area;
      end
   end

   always_comb begin
      grad_in[0] = DIFF_W'(req_corner1_y) - DIFF_W'(req_corner2_y);
      grad_in[1] = DIFF_W'(req_corner2_y) - DIFF_W'(req_corner0_y);
      grad_in[2] = DIFF_W'(req_corner0_y) - DIFF_W'(req_corner1_y);
      grad_in[3] = DIFF_W'(req_corner2_x) - DIFF_W'(req_corner1_x);
      grad_in[4] = DIFF_W'(req_corner0_x) - DIFF_W'(req_corner2_x);
      grad_in[5] = DIFF_W'(req_corner1_x) - DIFF_W'(req_corner0_x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < DIV_LAT; i++) begin
            aux_valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         a_valid_ff      <= req_valid;
         b_valid_ff      <= a_valid_ff;
         c_valid_ff      <= b_valid_ff;
         aux_valid_ff[0] <= c_valid_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            aux_valid_ff[i] <= aux_valid_ff[i-1];
         end
         out_valid_ff    <= aux_valid_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qx_ff <= DIFF_W'(req_point_x) - DIFF_W'(req_corner0_x);
         qy_ff <= DIFF_W'(req_point_y) - DIFF_W'(req_corner0_y);
         ux_ff <= DIFF_W'(req_corner1_x) - DIFF_W'(req_corner0_x);
         uy_ff <= DIFF_W'(req_corner1_y) - DIFF_W'(req_corner0_y);
         vx_ff <= DIFF_W'(req_corner2_x) - DIFF_W'(req_corner0_x);
         vy_ff <= DIFF_W'(req_corner2_y) - DIFF_W'(req_corner0_y);
         for (int i = 0; i < NUM_GRAD; i++) begin
            a_grad_ff[i] <= grad_in[i];
            b_grad_ff[i] <= a_grad_ff[i];
            c_grad_ff[i] <= b_grad_ff[i];
         end
         p_qxvy_ff <= PROD_W'(qx_ff) * PROD_W'(vy_ff);
         p_qyvx_ff <= PROD_W'(qy_ff) * PROD_W'(vx_ff);
         p_qyux_ff <= PROD_W'(qy_ff) * PROD_W'(ux_ff);
         p_qxuy_ff <= PROD_W'(qx_ff) * PROD_W'(uy_ff);
         p_uxvy_ff <= PROD_W'(ux_ff) * PROD_W'(vy_ff);
         p_vxuy_ff <= PROD_W'(vx_ff) * PROD_W'(uy_ff);
         n1_ff     <= NUM_W'(p_qxvy_ff) - NUM_W'(p_qyvx_ff);
         n2_ff     <= NUM_W'(p_qyux_ff) - NUM_W'(p_qxuy_ff);
         den_ff    <= NUM_W'(p_uxvy_ff) - NUM_W'(p_vxuy_ff);
      end
   end

   always_comb begin
      den_mag = den_ff[NUM_W-1] ? -den_ff : den_ff;
      nd_in   = NUM_W'(unsigned'(den_mag)) > NUM_W'(min_ff);
      div_num[0] = n1_ff;
      div_num[1] = n2_ff;
      for (int i = 0; i < NUM_GRAD; i++) begin
         div_num[i+2] = NUM_W'(c_grad_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         aux_nd_ff[0]  <= nd_in;
         aux_den_ff[0] <= den_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            aux_nd_ff[i]  <= aux_nd_ff[i-1];
            aux_den_ff[i] <= aux_den_ff[i-1];
         end
      end
   end

   for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
      tbg_div u_div (
         .clock (clock),
         .en    (en),
         .num   (div_num[g]),
         .den   (den_ff),
         .quot  (div_q[g])
      );
   end

   // weight 0 = one minus the saturated weights 1 and 2
   always_comb begin
      w0_sum = (OUT_W+2)'(1) << FRAC_W;
      w0_sum = w0_sum - (OUT_W+2)'(div_q[0]) - (OUT_W+2)'(div_q[1]);
      if (w0_sum > $signed((OUT_W+2)'({1'b0, {(OUT_W-1){1'b1}}}))) begin
         out_in[0] = {1'b0, {(OUT_W-1){1'b1}}};
      end else if (w0_sum < -((OUT_W+2)'(1) << (OUT_W-1))) begin
         out_in[0] = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         out_in[0] = OUT_W'(w0_sum);
      end
      for (int i = 0; i < NUM_DIV; i++) begin
         out_in[i+1] = div_q[i];
      end
      res_in  = aux_nd_ff[DIV_LAT-1];
      area_in = AREA_W'(aux_den_ff[DIV_LAT-1]);
      if (!res_in) begin
         for (int i = 0; i <= NUM_DIV; i++) begin
            out_in[i] = '0;
         end
         area_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= NUM_DIV; i++) begin
            out_ff[i] <= out_in[i];
         end
         area_ff <= area_in;
         res_ff  <= res_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_weight0      = out_ff[0];
   assign rsp_weight1      = out_ff[1];
   assign rsp_weight2      = out_ff[2];
   assign rsp_grad0_dx     = out_ff[3];
   assign rsp_grad1_dx     = out_ff[4];
   assign rsp_grad2_dx     = out_ff[5];
   assign rsp_grad0_dy     = out_ff[6];
   assign rsp_grad1_dy     = out_ff[7];
   assign rsp_grad2_dy     = out_ff[8];
   assign rsp_doubled_area = area_ff;
   assign rsp_valid_res    = res_ff;

   `TBG_ASSERT(a_degen_zero, rsp_valid && !rsp_valid_res, rsp_doubled_area == '0 && rsp_weight0 == '0)
   `TBG_ASSERT(a_good_area, rsp_valid && rsp_valid_res, rsp_doubled_area != '0)
   `TBG_ASSERT_NEXT(a_enter, req_valid && req_ready, a_valid_ff)
   `TBG_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, $stable(c_valid_ff) && $stable(rsp_valid))
endmodule

/* tb/tb.sv */
// Self-checking testbench for the triangle barycentric weights and gradients block.
module tb;
   import tbg_pkg::*;

   typedef struct {
      logic signed [COORD_W-1:0] c [8];   // px, py, x0, y0, x1, y1, x2, y2
   } tri_item_type;

   typedef struct {
      logic signed [OUT_W-1:0]  f [9];
      logic signed [AREA_W-1:0] area;
      logic                     ok;
   } bary_res_type;

   // Scoreboard: predicts weights and gradients, holds them in order, checks results.
   class bary_scoreboard_type;
      bary_res_type pending[$];
      logic [MIN_W-1:0] min_area;
      int errors;
      string names[9] = '{"weight0", "weight1", "weight2", "grad0_dx", "grad1_dx",
                          "grad2_dx", "grad0_dy", "grad1_dy", "grad2_dy"};

      function longint fx_quot(longint num, longint den);
         longint unsigned n, d, a, r, f, m;
         bit neg;
         n = num < 0 ? -num : num;
         d = den < 0 ? -den : den;
         neg = (num < 0) != (den < 0);
         a = n / d;
         r = n % d;
         f = 0;
         if (a >= (64'd1 << INT_BITS)) m = 64'd1 << 32;
         else begin
            for (int i = 0; i < FRAC_W; i++) begin
               r = r << 1;
               f = f << 1;
               if (r >= d) begin
                  r = r - d;
                  f = f | 1;
               end
            end
            m = (a << FRAC_W) + f + (((r << 1) >= d) ? 1 : 0);
         end
         if (neg) return m > (64'd1 << 31) ? -longint'(64'd1 << 31) : -longint'(m);
         return m > 64'h7fff_ffff ? longint'(64'h7fff_ffff) : longint'(m);
      endfunction

      function void note_triangle(tri_item_type t);
         bary_res_type e;
         longint p[8], qx, qy, ux, uy, vx, vy, n1, n2, den, w1, w2, w0;
         for (int i = 0; i < 8; i++) p[i] = t.c[i];
         qx = p[0] - p[2];  qy = p[1] - p[3];
         ux = p[4] - p[2];  uy = p[5] - p[3];
         vx = p[6] - p[2];  vy = p[7] - p[3];
         n1 = qx * vy - qy * vx;
         n2 = qy * ux - qx * uy;
         den = ux * vy - vx * uy;
         foreach (e.f[i]) e.f[i] = '0;
         e.area = '0;
         e.ok = 1'b0;
         if ((den < 0 ? -den : den) > longint'(min_area)) begin
            w1 = fx_quot(n1, den);
            w2 = fx_quot(n2, den);
            w0 = (longint'(1) << FRAC_W) - w1 - w2;
            if (w0 > 64'sh7fff_ffff) w0 = 64'sh7fff_ffff;
            if (w0 < -64'sh8000_0000) w0 = -64'sh8000_0000;
            e.f[0] = OUT_W'(w0);
            e.f[1] = OUT_W'(w1);
            e.f[2] = OUT_W'(w2);
            e.f[3] = OUT_W'(fx_quot(-(p[7] - p[5]), den));
            e.f[4] = OUT_W'(fx_quot(-(p[3] - p[7]), den));
            e.f[5] = OUT_W'(fx_quot(-(p[5] - p[3]), den));
            e.f[6] = OUT_W'(fx_quot(p[6] - p[4], den));
            e.f[7] = OUT_W'(fx_quot(p[2] - p[6], den));
            e.f[8] = OUT_W'(fx_quot(p[4] - p[2], den));
            e.area = AREA_W'(den);
            e.ok = 1'b1;
         end
         pending.push_back(e);
      endfunction

      function void check_result(bary_res_type got);
         bary_res_type e;
         if (pending.size() == 0) begin
            $error("result transaction with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         for (int i = 0; i < 9; i++)
            if (got.f[i] !== e.f[i]) begin
               $error("%s expected %0d actual %0d", names[i], e.f[i], got.f[i]);
               errors++;
            end
         if (got.area !== e.area) begin
            $error("doubled_area expected %0d actual %0d", e.area, got.area);
            errors++;
         end
         if (got.ok !== e.ok) begin
            $error("valid_res expected %0d actual %0d", e.ok, got.ok);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic csr_valid = 0, csr_ready;
   logic [MIN_W-1:0] csr_min_twice_area = '0;
   logic req_valid = 0, req_ready;
   logic signed [COORD_W-1:0] req_c [8];
   logic rsp_valid, rsp_ready = 0;
   logic signed [OUT_W-1:0] rsp_f [9];
   logic signed [AREA_W-1:0] rsp_doubled_area;
   logic rsp_valid_res;
   bit quiet = 0;   // no idling on either side
   bary_scoreboard_type sb = new();

   initial foreach (req_c[i]) req_c[i] = '0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   triangle_barycentric_gradients i_dut (
      .clock, .reset, .csr_valid, .csr_ready, .csr_min_twice_area,
      .req_valid, .req_ready,
      .req_point_x(req_c[0]), .req_point_y(req_c[1]),
      .req_corner0_x(req_c[2]), .req_corner0_y(req_c[3]),
      .req_corner1_x(req_c[4]), .req_corner1_y(req_c[5]),
      .req_corner2_x(req_c[6]), .req_corner2_y(req_c[7]),
      .rsp_valid, .rsp_ready,
      .rsp_weight0(rsp_f[0]), .rsp_weight1(rsp_f[1]), .rsp_weight2(rsp_f[2]),
      .rsp_grad0_dx(rsp_f[3]), .rsp_grad1_dx(rsp_f[4]), .rsp_grad2_dx(rsp_f[5]),
      .rsp_grad0_dy(rsp_f[6]), .rsp_grad1_dy(rsp_f[7]), .rsp_grad2_dy(rsp_f[8]),
      .rsp_doubled_area, .rsp_valid_res
   );

   always @(posedge clock) begin
      bary_res_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         foreach (got.f[i]) got.f[i] = rsp_f[i];
         got.area = rsp_doubled_area;
         got.ok = rsp_valid_res;
         sb.check_result(got);
      end
   end

   always @(negedge clock)
      rsp_ready <= quiet || ($urandom_range(99) >= 12);

   // valid stays high between back-to-back transactions; it drops only on idling
   task automatic send_triangle(tri_item_type t);
      while (!quiet && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      foreach (req_c[i]) req_c[i] <= t.c[i];
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_triangle(t);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DIV_LAT + 10) @(negedge clock);
   endtask

   task automatic write_threshold(logic [MIN_W-1:0] v);
      csr_min_twice_area <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.min_area = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord(int spread);
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         1: return COORD_W'($urandom);
         default: return COORD_W'($signed($urandom_range(2 * spread)) - spread);
      endcase
   endfunction

   function automatic tri_item_type rand_triangle();
      tri_item_type t;
      int spread;
      spread = $urandom_range(1) ? 32767 : $urandom_range(1, 300);
      foreach (t.c[i]) t.c[i] = rand_coord(spread);
      case ($urandom_range(9))
         0: begin   // collinear corners
            t.c[6] = t.c[4];
            t.c[7] = t.c[5];
         end
         1: begin   // point on a corner
            t.c[0] = t.c[4];
            t.c[1] = t.c[5];
         end
         default: ;
      endcase
      return t;
   endfunction

   function automatic tri_item_type mk(int a, int b, int c, int d, int e, int f, int g, int h);
      tri_item_type t;
      t.c = '{COORD_W'(a), COORD_W'(b), COORD_W'(c), COORD_W'(d),
              COORD_W'(e), COORD_W'(f), COORD_W'(g), COORD_W'(h)};
      return t;
   endfunction

   initial begin
      tri_item_type dir[$];
      logic [MIN_W-1:0] thr[5] = '{34'd0, 34'd1, 34'd5000, 34'd100000000, {MIN_W{1'b1}}};
      sb.min_area = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      dir.push_back(mk(0, 0, 0, 0, 16, 0, 0, 16));
      dir.push_back(mk(5, 5, 0, 0, 16, 0, 0, 16));
      dir.push_back(mk(8, 8, 0, 0, 0, 16, 16, 0));          // clockwise
      dir.push_back(mk(3, 4, 0, 0, 1, 1, 2, 2));            // zero area
      dir.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
      dir.push_back(mk(0, 0, 0, 0, 1, 0, 0, 1));            // smallest area
      dir.push_back(mk(32767, 32767, 0, 0, 1, 0, 0, 1));    // weights saturate
      dir.push_back(mk(-32768, -32768, 0, 0, 1, 0, 0, 1));
      dir.push_back(mk(0, 0, -32768, -32768, 32767, -32768, -32768, 32767));
      dir.push_back(mk(-32768, 32767, 32767, 32767, -32768, 32767, 32767, -32768));
      dir.push_back(mk(-1, -1, -32768, 32767, 32767, -32768, 32767, 32767));
      dir.push_back(mk(1, 1, 0, 0, 3, 0, 0, 3));            // weights of one third, rounded
      dir.push_back(mk(16, 0, 0, 0, 16, 0, 0, 16));         // point on corner
      dir.push_back(mk(8, 0, 0, 0, 16, 0, 0, 16));          // point on edge
      quiet = 1;
      foreach (dir[i]) send_triangle(dir[i]);
      quiet = 0;
      drain();
      foreach (thr[k]) begin
         write_threshold(thr[k]);
         foreach (dir[i]) send_triangle(dir[i]);
         for (int n = 0; n < 210; n++) begin
            quiet = (k == 2 && n >= 40 && n < 140);
            send_triangle(rand_triangle());
            if (n == 100) drain();   // hold off until all results are back
         end
         quiet = 0;
         drain();
      end
      if (sb.errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+src
src/tbg_pkg.sv
src/tbg_div.sv
src/triangle_barycentric_gradients.sv
tb/tb.sv
